### rtl/ttoi_pkg.sv
package ttoi_pkg;

	localparam int CHAR_W         = 8;
	localparam int VALUE_W        = 32;
	localparam int STATUS_W       = 2;
	localparam int M_TDATA_W      = 40;
	localparam int DIGIT_COUNT_W  = 5;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 64;
	localparam int DIGITS_PER_REG = 8;
	localparam int ALPHABET_W     = 2 * CFG_DATA_W;

	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

	localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_ALPHABET = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR     = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNUSED       = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DIGITS_LOW  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DIGITS_HIGH = 2'd2;

endpackage

### rtl/ttoi_alphabet.sv
module ttoi_alphabet #(
	parameter int MAX_DIGITS = 16
) (
	input  logic [ttoi_pkg::DIGIT_COUNT_W-1:0]         digit_count,
	input  logic [MAX_DIGITS*ttoi_pkg::CHAR_W-1:0]     digits,
	input  logic [ttoi_pkg::CHAR_W-1:0]                character,
	output logic                                       alphabet_ok,
	output logic                                       digit_hit,
	output logic [$clog2(MAX_DIGITS)-1:0]              digit_pos,
	output logic [$clog2(MAX_DIGITS+1)-1:0]            radix
);
	import ttoi_pkg::*;

	localparam int POS_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	logic [CHAR_W-1:0]     digit_byte [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] in_use;

	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			digit_byte[i] = digits[i*CHAR_W +: CHAR_W];
			in_use[i] = DIGIT_COUNT_W'(i) < digit_count;
		end
	end

	always_comb begin
		alphabet_ok = (digit_count >= DIGIT_COUNT_W'(2)) &&
			(digit_count <= DIGIT_COUNT_W'(MAX_DIGITS));
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (in_use[i] && (digit_byte[i] == CHAR_PLUS || digit_byte[i] == CHAR_MINUS ||
					digit_byte[i] == CHAR_SPACE || digit_byte[i] == CHAR_NUL)) begin
				alphabet_ok = 1'b0;
			end
			for (int j = i + 1; j < MAX_DIGITS; j++) begin
				if (in_use[j] && digit_byte[i] == digit_byte[j]) begin
					alphabet_ok = 1'b0;
				end
			end
		end
	end

	always_comb begin
		digit_hit = 1'b0;
		digit_pos = '0;
		for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
			if (in_use[i] && digit_byte[i] == character) begin
				digit_hit = 1'b1;
				digit_pos = POS_W'(i);
			end
		end
	end

	assign radix = (digit_count > DIGIT_COUNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS)
		: CNT_W'(digit_count);

endmodule

### rtl/text_to_integer_custom_base_top.sv
// Converts a number string, one character per item, into a signed integer in a
// configurable digit alphabet of up to MAX_DIGITS characters. The block takes one item
// in every cycle unless a terminator is held: each character is held in an input
// register, and in the next cycle the digit lookup and one multiply-add by the radix
// update the accumulator. A zero character ends the string and puts one result in the
// output register (value in bits 31:0, status in bits 33:32). Other characters keep
// flowing while a result waits; only a terminator waits on a full output register.
// The user must write configuration only while no string is open (not enforced).
module text_to_integer_custom_base_top #(
	parameter int MAX_DIGITS  = 16,
	parameter int RESULT_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [ttoi_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] character
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [ttoi_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] value, [33:32] status
	input  logic                                cfg_we,
	input  logic [ttoi_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ttoi_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ttoi_pkg::*;

	localparam int POS_W = $clog2(MAX_DIGITS);
	localparam int CNT_W = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {
		PH_SPACE = 2'd0,
		PH_SIGN  = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	logic [DIGIT_COUNT_W-1:0] digit_count_q;
	logic [CFG_DATA_W-1:0]    digits_low_q;
	logic [CFG_DATA_W-1:0]    digits_high_q;
	logic [ALPHABET_W-1:0]    alphabet;

	logic                     valid_s1;
	logic [CHAR_W-1:0]        char_s1;
	logic                     valid_s2;
	logic [VALUE_W-1:0]       value_s2;
	logic [STATUS_W-1:0]      status_s2;

	phase_t                   phase_q;
	logic                     negative_q;
	logic [RESULT_BITS-1:0]   acc_q;
	logic                     bad_q;

	logic                     alphabet_ok;
	logic                     digit_hit;
	logic [POS_W-1:0]         digit_pos;
	logic [CNT_W-1:0]         radix;

	logic                     is_term;
	logic                     is_space;
	logic                     is_sign;
	logic                     advance;
	logic [RESULT_BITS+CNT_W-1:0] product;
	logic [RESULT_BITS-1:0]   acc_next;
	logic [RESULT_BITS-1:0]   signed_acc;
	logic [VALUE_W-1:0]       value_next;
	logic [STATUS_W-1:0]      status_next;

	assign alphabet = {digits_high_q, digits_low_q};

	ttoi_alphabet #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_alphabet (
		.digit_count(digit_count_q),
		.digits     (alphabet[MAX_DIGITS*CHAR_W-1:0]),
		.character  (char_s1),
		.alphabet_ok(alphabet_ok),
		.digit_hit  (digit_hit),
		.digit_pos  (digit_pos),
		.radix      (radix)
	);

	assign is_term  = char_s1 == CHAR_NUL;
	assign is_space = (char_s1 >= CHAR_TAB && char_s1 <= CHAR_CR) || char_s1 == CHAR_SPACE;
	assign is_sign  = char_s1 == CHAR_PLUS || char_s1 == CHAR_MINUS;

	assign advance  = valid_s1 && (!is_term || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	assign product  = acc_q * radix;
	assign acc_next = product[RESULT_BITS-1:0] + RESULT_BITS'(digit_pos);

	always_comb begin
		signed_acc  = negative_q ? (~acc_q + RESULT_BITS'(1)) : acc_q;
		value_next  = '0;
		status_next = STATUS_OK;
		if (!alphabet_ok) begin
			status_next = STATUS_BAD_ALPHABET;
		end else if (bad_q) begin
			status_next = STATUS_BAD_CHAR;
		end else begin
			value_next = VALUE_W'(signed_acc);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			digits_low_q  <= '0;
			digits_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DIGIT_COUNT: digit_count_q <= cfg_data[DIGIT_COUNT_W-1:0];
				REG_DIGITS_LOW:  digits_low_q  <= cfg_data;
				REG_DIGITS_HIGH: digits_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SPACE;
			negative_q <= 1'b0;
			acc_q      <= '0;
			bad_q      <= 1'b0;
		end else if (advance) begin
			if (is_term) begin
				phase_q    <= PH_SPACE;
				negative_q <= 1'b0;
				acc_q      <= '0;
				bad_q      <= 1'b0;
			end else begin
				case (phase_q)
					PH_SPACE, PH_SIGN: begin
						if (phase_q == PH_SPACE && is_space) begin
							phase_q <= PH_SPACE;
						end else if (is_sign) begin
							phase_q <= PH_SIGN;
							if (char_s1 == CHAR_MINUS) begin
								negative_q <= !negative_q;
							end
						end else begin
							phase_q <= PH_DIGIT;
							if (digit_hit) begin
								acc_q <= acc_next;
							end else begin
								bad_q <= 1'b1;
							end
						end
					end
					default: begin
						if (digit_hit) begin
							acc_q <= acc_next;
						end else begin
							bad_q <= 1'b1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && is_term) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_term) begin
			value_s2  <= value_next;
			status_s2 <= status_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(M_TDATA_W - VALUE_W - STATUS_W)'(0), status_s2, value_s2};

endmodule

### rtl/ttoi_checker.sv
module ttoi_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [ttoi_pkg::CHAR_W-1:0]       s_tdata,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [ttoi_pkg::M_TDATA_W-1:0]    m_tdata
);
	import ttoi_pkg::*;

	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  value;

	assign status = m_tdata[VALUE_W +: STATUS_W];
	assign value  = m_tdata[VALUE_W-1:0];

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> status != STATUS_UNUSED)
		else $error("unused status code on result");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status != STATUS_OK |-> value == '0)
		else $error("rejected result carries a nonzero value");

	// A terminator taken in the previous cycle may still produce its result.
	a_result_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata != CHAR_NUL && !m_tvalid &&
		!$past(s_tvalid && s_tready && s_tdata == CHAR_NUL) |=> !m_tvalid)
		else $error("result without a terminator");

endmodule

bind text_to_integer_custom_base_top ttoi_checker u_ttoi_checker (.*);

### verif/ttoi_result_checker.sv
module ttoi_result_checker #(
	parameter int MAX_DIGITS  = 16,
	parameter int RESULT_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [ttoi_pkg::CHAR_W-1:0]       s_tdata,   // [7:0] character
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [ttoi_pkg::M_TDATA_W-1:0]    m_tdata,   // [31:0] value, [33:32] status
	input  logic                              cfg_we,
	input  logic [ttoi_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [ttoi_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                mismatches,
	output int                                awaited
);
	import ttoi_pkg::*;

	typedef enum logic [1:0] {
		SCAN_SPACE,
		SCAN_SIGN,
		SCAN_DIGITS
	} scan_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  value;
	} parse_t;

	localparam logic [63:0] ACC_MASK = (RESULT_BITS >= 64) ? '1 :
		((64'd1 << RESULT_BITS) - 64'd1);

	logic [DIGIT_COUNT_W-1:0] radix_reg;
	logic [ALPHABET_W-1:0]    alphabet;
	scan_t                    scan;
	logic                     negative;
	logic [63:0]              accumulator;
	logic                     bad_char;
	parse_t                   expected_parses[$];
	int                       mismatch_count;

	function automatic int radix_used();
		return (radix_reg > MAX_DIGITS) ? MAX_DIGITS : int'(radix_reg);
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(int pos);
		return alphabet[pos*CHAR_W +: CHAR_W];
	endfunction

	function automatic bit alphabet_ok();
		int n;
		logic [CHAR_W-1:0] c;
		n = int'(radix_reg);
		if (n < 2 || n > MAX_DIGITS)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			c = digit_char(i);
			if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE)
				return 1'b0;
			for (int j = i + 1; j < n; j++)
				if (digit_char(j) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// A duplicated digit resolves to its lowest position.
	function automatic int digit_value(logic [CHAR_W-1:0] c);
		for (int i = 0; i < radix_used(); i++)
			if (digit_char(i) == c)
				return i;
		return -1;
	endfunction

	task automatic parse_char(logic [CHAR_W-1:0] c);
		parse_t res;
		int d;
		if (c == CHAR_NUL) begin
			res = '0;
			res.status = STATUS_OK;
			if (!alphabet_ok())
				res.status = STATUS_BAD_ALPHABET;
			else if (bad_char)
				res.status = STATUS_BAD_CHAR;
			else if (negative)
				res.value = VALUE_W'((64'd0 - accumulator) & ACC_MASK);
			else
				res.value = VALUE_W'(accumulator);
			expected_parses.push_back(res);
			scan = SCAN_SPACE;
			negative = 1'b0;
			accumulator = '0;
			bad_char = 1'b0;
		end else if (scan != SCAN_SPACE ||
				!((c >= CHAR_TAB && c <= CHAR_CR) || c == CHAR_SPACE)) begin
			if (scan != SCAN_DIGITS && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
				scan = SCAN_SIGN;
				if (c == CHAR_MINUS)
					negative = !negative;
			end else begin
				scan = SCAN_DIGITS;
				d = digit_value(c);
				if (d < 0)
					bad_char = 1'b1;
				else
					accumulator = (accumulator * 64'(radix_used()) + 64'(d)) & ACC_MASK;
			end
		end
	endtask

	task automatic check_result(logic [M_TDATA_W-1:0] word);
		parse_t want;
		logic [VALUE_W-1:0] got_value;
		logic [STATUS_W-1:0] got_status;
		got_value = word[VALUE_W-1:0];
		got_status = word[VALUE_W +: STATUS_W];
		if (expected_parses.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected result: value %0d status %0d",
					$signed(got_value), got_status);
		end else begin
			want = expected_parses.pop_front();
			if (got_value !== want.value || got_status !== want.status) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("wrong result: value %0d (want %0d) status %0d (want %0d)",
						$signed(got_value), $signed(want.value), got_status, want.status);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_reg = '0;
			alphabet = '0;
			scan = SCAN_SPACE;
			negative = 1'b0;
			accumulator = '0;
			bad_char = 1'b0;
			expected_parses.delete();
			mismatch_count = 0;
			mismatches <= 0;
			awaited <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				parse_char(s_tdata);
			if (cfg_we) begin
				case (cfg_index)
					REG_DIGIT_COUNT: radix_reg = cfg_data[DIGIT_COUNT_W-1:0];
					REG_DIGITS_LOW:  alphabet[CFG_DATA_W-1:0] = cfg_data;
					REG_DIGITS_HIGH: alphabet[ALPHABET_W-1:CFG_DATA_W] = cfg_data;
					default: ;
				endcase
			end
			mismatches <= mismatch_count;
			awaited <= expected_parses.size();
		end
	end

endmodule

### verif/text_to_integer_custom_base_top_tb.sv
module text_to_integer_custom_base_top_tb;
	import ttoi_pkg::*;

	localparam int MAX_DIGITS   = 16;
	localparam int RESULT_BITS  = 32;
	localparam int ITEM_GOAL    = 850;
	localparam int IDLE_PERCENT = 32;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [CHAR_W-1:0] char_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [CHAR_W-1:0]      s_tdata = '0;      // [7:0] character
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;           // [31:0] value, [33:32] status
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int mismatches;
	int awaited;
	bit steady = 1'b0;
	int stall_cycles = 0;
	int items_sent = 0;

	text_to_integer_custom_base_top #(
		.MAX_DIGITS(MAX_DIGITS),
		.RESULT_BITS(RESULT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	ttoi_result_checker #(
		.MAX_DIGITS(MAX_DIGITS),
		.RESULT_BITS(RESULT_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.awaited(awaited)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("text_to_integer_custom_base_top: mismatch");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	function automatic logic [ALPHABET_W-1:0] pack_digits(string text);
		logic [ALPHABET_W-1:0] alpha;
		alpha = '0;
		for (int i = 0; i < text.len() && i < MAX_DIGITS; i++)
			alpha[i*CHAR_W +: CHAR_W] = text[i];
		return alpha;
	endfunction

	task automatic load_alphabet(logic [DIGIT_COUNT_W-1:0] count,
			logic [ALPHABET_W-1:0] alpha);
		cfg_we <= 1'b1;
		cfg_index <= REG_DIGIT_COUNT;
		cfg_data <= CFG_DATA_W'(count);
		@(posedge clk);
		cfg_index <= REG_DIGITS_LOW;
		cfg_data <= alpha[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_index <= REG_DIGITS_HIGH;
		cfg_data <= alpha[ALPHABET_W-1:CFG_DATA_W];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic present_char(char_t c);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_text(string text);
		for (int i = 0; i < text.len(); i++)
			present_char(text[i]);
		present_char(CHAR_NUL);
		items_sent += text.len() + 1;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (awaited != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly valid alphabets; the rest get a bad size, a duplicate or a forbidden digit.
	task automatic pick_alphabet(output logic [DIGIT_COUNT_W-1:0] count,
			output logic [ALPHABET_W-1:0] alpha);
		int n;
		int roll;
		int pos;
		int src;
		char_t c;
		bit clash;
		alpha = {$urandom(), $urandom(), $urandom(), $urandom()};
		roll = $urandom_range(0, 3);
		if (roll == 0)
			n = MAX_DIGITS;
		else if (roll == 1)
			n = $urandom_range(2, 4);
		else
			n = $urandom_range(2, MAX_DIGITS);
		for (int i = 0; i < n; i++) begin
			do begin
				c = char_t'($urandom_range(1, 255));
				clash = (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_SPACE);
				for (int j = 0; j < i; j++)
					if (alpha[j*CHAR_W +: CHAR_W] == c)
						clash = 1'b1;
			end while (clash);
			alpha[i*CHAR_W +: CHAR_W] = c;
		end
		roll = $urandom_range(0, 9);
		if (roll == 7) begin
			roll = $urandom_range(0, 2);
			n = (roll == 0) ? 0 : (roll == 1) ? 1 : $urandom_range(MAX_DIGITS + 1, 31);
		end else if (roll == 8) begin
			pos = $urandom_range(1, n - 1);
			src = $urandom_range(0, pos - 1);
			alpha[pos*CHAR_W +: CHAR_W] = alpha[src*CHAR_W +: CHAR_W];
		end else if (roll == 9) begin
			pos = $urandom_range(0, n - 1);
			roll = $urandom_range(0, 3);
			c = (roll == 0) ? CHAR_NUL : (roll == 1) ? CHAR_PLUS :
				(roll == 2) ? CHAR_MINUS : CHAR_SPACE;
			alpha[pos*CHAR_W +: CHAR_W] = c;
		end
		count = DIGIT_COUNT_W'(n);
	endtask

	task automatic send_random_string(logic [DIGIT_COUNT_W-1:0] count,
			logic [ALPHABET_W-1:0] alpha);
		char_t text[$];
		int radix;
		int len;
		int pos;
		int blanks;
		int signs;
		char_t c;
		radix = (count > MAX_DIGITS) ? MAX_DIGITS : int'(count);
		blanks = $urandom_range(0, 3);
		repeat (blanks) begin
			pos = $urandom_range(9, 14);
			text.push_back((pos == 14) ? CHAR_SPACE : CHAR_W'(pos));
		end
		signs = $urandom_range(0, 3);
		repeat (signs)
			text.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
		len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 16) : $urandom_range(0, 6);
		repeat (len) begin
			if (radix == 0) begin
				c = char_t'($urandom_range(1, 255));
			end else begin
				pos = $urandom_range(0, radix - 1);
				c = alpha[pos*CHAR_W +: CHAR_W];
			end
			// A zero digit in a broken alphabet would end the string early.
			if (c == CHAR_NUL)
				c = CHAR_PLUS;
			text.push_back(c);
		end
		if ($urandom_range(0, 99) < 15) begin
			c = char_t'($urandom_range(1, 255));
			pos = $urandom_range(0, text.size());
			text.insert(pos, c);
		end
		foreach (text[i])
			present_char(text[i]);
		present_char(CHAR_NUL);
		items_sent += text.size() + 1;
	endtask

	initial begin
		logic [DIGIT_COUNT_W-1:0] count;
		logic [ALPHABET_W-1:0] alpha;
		int strings;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The alphabet is empty out of reset, so the first string is rejected.
		send_text("");
		settle();
		load_alphabet(DIGIT_COUNT_W'(16), pack_digits("0123456789ABCDEF"));
		send_text("\t\015 -+-FF");
		send_text("-\377");
		send_text("+ 1");
		send_text("");
		settle();
		load_alphabet(DIGIT_COUNT_W'(31), '1);
		send_text("\377");
		settle();
		load_alphabet(DIGIT_COUNT_W'(2), pack_digits("\001\377"));
		send_text("-\377\001\377");
		settle();
		load_alphabet(DIGIT_COUNT_W'(3), pack_digits("a+b"));
		send_text("b");
		settle();
		load_alphabet(DIGIT_COUNT_W'(4), pack_digits("abca"));
		send_text("a");
		settle();

		while (items_sent < ITEM_GOAL) begin
			steady <= (items_sent >= 300 && items_sent < 450);
			pick_alphabet(count, alpha);
			load_alphabet(count, alpha);
			strings = $urandom_range(3, 10);
			repeat (strings) send_random_string(count, alpha);
			settle();
		end

		if (mismatches == 0 && awaited == 0) begin
			$display("text_to_integer_custom_base_top: match");
		end else begin
			$display("text_to_integer_custom_base_top: mismatch");
		end
		$finish;
	end

endmodule
